@@ sv/utf8v_pkg.sv @@
package utf8v_pkg;

    // allowed range of the byte that follows a lead byte
    typedef enum logic [2:0] {
        CLS_NORMAL = 3'd0,  // 80..BF
        CLS_E0     = 3'd1,  // A0..BF
        CLS_ED     = 3'd2,  // 80..9F
        CLS_F0     = 3'd3,  // 90..BF
        CLS_F4     = 3'd4   // 80..8F
    } second_class_t;

    typedef struct packed {
        logic [1:0]    cont_left;
        second_class_t second_class;
        logic          at_second;
        logic          error_seen;
    } utf8v_state_t;

    localparam utf8v_state_t STATE_CLEAR = '{
        cont_left:    2'd0,
        second_class: CLS_NORMAL,
        at_second:    1'b0,
        error_seen:   1'b0
    };

    localparam logic [7:0] BYTE_TERM   = 8'h00;
    localparam logic [7:0] BYTE_TAB    = 8'h09;
    localparam logic [7:0] BYTE_LF     = 8'h0A;
    localparam logic [7:0] BYTE_CR     = 8'h0D;
    localparam logic [7:0] PRINT_LO    = 8'h20;
    localparam logic [7:0] PRINT_HI    = 8'h7E;
    localparam logic [7:0] CONT_LO     = 8'h80;
    localparam logic [7:0] CONT_HI     = 8'hBF;
    localparam logic [7:0] LEAD2_LO    = 8'hC2;
    localparam logic [7:0] LEAD2_HI    = 8'hDF;
    localparam logic [7:0] LEAD3_E0    = 8'hE0;
    localparam logic [7:0] LEAD3_ED    = 8'hED;
    localparam logic [7:0] LEAD3_HI    = 8'hEF;
    localparam logic [7:0] LEAD4_F0    = 8'hF0;
    localparam logic [7:0] LEAD4_F4    = 8'hF4;
    localparam logic [7:0] SEC_E0_LO   = 8'hA0;
    localparam logic [7:0] SEC_ED_HI   = 8'h9F;
    localparam logic [7:0] SEC_F0_LO   = 8'h90;
    localparam logic [7:0] SEC_F4_HI   = 8'h8F;

endpackage

@@ sv/utf8v_step.sv @@
module utf8v_step
    import utf8v_pkg::*;
(
    input  logic [7:0]   data_byte,
    input  utf8v_state_t state_cur,
    output utf8v_state_t state_nxt,
    output logic         string_valid
);

    logic         is_term;
    logic         cont_ok;
    logic         sec_ok;
    logic         plain_ok;
    utf8v_state_t lead_nxt;
    utf8v_state_t cont_nxt;

    assign is_term = (data_byte == BYTE_TERM);
    assign string_valid = !state_cur.error_seen && (state_cur.cont_left == 2'd0);
    assign cont_ok = (data_byte >= CONT_LO) && (data_byte <= CONT_HI);

    always_comb begin
        unique case (state_cur.second_class)
            CLS_E0:  sec_ok = (data_byte >= SEC_E0_LO) && (data_byte <= CONT_HI);
            CLS_ED:  sec_ok = (data_byte >= CONT_LO) && (data_byte <= SEC_ED_HI);
            CLS_F0:  sec_ok = (data_byte >= SEC_F0_LO) && (data_byte <= CONT_HI);
            CLS_F4:  sec_ok = (data_byte >= CONT_LO) && (data_byte <= SEC_F4_HI);
            default: sec_ok = cont_ok;
        endcase
    end

    assign plain_ok = (data_byte == BYTE_TAB) || (data_byte == BYTE_LF)
                   || (data_byte == BYTE_CR)
                   || ((data_byte >= PRINT_LO) && (data_byte <= PRINT_HI));

    always_comb begin
        lead_nxt = state_cur;
        priority if (plain_ok) begin
            lead_nxt = state_cur;
        end else if ((data_byte >= LEAD2_LO) && (data_byte <= LEAD2_HI)) begin
            lead_nxt = '{cont_left: 2'd1, second_class: CLS_NORMAL, at_second: 1'b1,
                         error_seen: 1'b0};
        end else if (data_byte == LEAD3_E0) begin
            lead_nxt = '{cont_left: 2'd2, second_class: CLS_E0, at_second: 1'b1,
                         error_seen: 1'b0};
        end else if (data_byte == LEAD3_ED) begin
            lead_nxt = '{cont_left: 2'd2, second_class: CLS_ED, at_second: 1'b1,
                         error_seen: 1'b0};
        end else if ((data_byte > LEAD3_E0) && (data_byte <= LEAD3_HI)) begin
            lead_nxt = '{cont_left: 2'd2, second_class: CLS_NORMAL, at_second: 1'b1,
                         error_seen: 1'b0};
        end else if (data_byte == LEAD4_F0) begin
            lead_nxt = '{cont_left: 2'd3, second_class: CLS_F0, at_second: 1'b1,
                         error_seen: 1'b0};
        end else if (data_byte == LEAD4_F4) begin
            lead_nxt = '{cont_left: 2'd3, second_class: CLS_F4, at_second: 1'b1,
                         error_seen: 1'b0};
        end else if ((data_byte > LEAD4_F0) && (data_byte < LEAD4_F4)) begin
            lead_nxt = '{cont_left: 2'd3, second_class: CLS_NORMAL, at_second: 1'b1,
                         error_seen: 1'b0};
        end else begin
            lead_nxt.error_seen = 1'b1;
        end
    end

    always_comb begin
        cont_nxt              = state_cur;
        cont_nxt.at_second    = 1'b0;
        cont_nxt.second_class = CLS_NORMAL;
        if (state_cur.at_second ? sec_ok : cont_ok) begin
            cont_nxt.cont_left = state_cur.cont_left - 2'd1;
        end else begin
            cont_nxt.error_seen = 1'b1;
            cont_nxt.cont_left  = 2'd0;
        end
    end

    always_comb begin
        priority if (is_term) begin
            state_nxt = STATE_CLEAR;
        end else if (state_cur.error_seen) begin
            // bytes after an error are dropped until the terminator
            state_nxt = state_cur;
        end else if (state_cur.cont_left != 2'd0) begin
            state_nxt = cont_nxt;
        end else begin
            state_nxt = lead_nxt;
        end
    end

endmodule

@@ sv/utf8_stream_validator_unit.sv @@
// strict utf-8 string checker, one byte per transaction
//
// s_ channel: one string byte per transaction in s_tdata; a zero byte ends
// the string. m_ channel: one result transaction per string, sent for the
// terminator only; m_tdata[0] is 1 when the whole string was valid.
// Non-zero bytes produce no result transaction.
//
// A byte lands in an input register and is checked there by a
// few range compares against the lead/continuation state, which writes the
// result register. Throughput: 1 byte per cycle, except while a terminator
// waits in the input register for the output register to be free.
//
// When the receiver holds m_tready low, the result waits in the output
// register and bytes keep flowing; only a second terminator stalls in the
// input register, so s_tready drops until the result is taken.
// Reset (aresetn low, synchronous) empties both registers and clears the
// checker state, so the next byte starts a new string.
module utf8_stream_validator_unit
    import utf8v_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] string_valid, [7:1] zero
);

    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;
    logic         out_valid_reg;
    logic         out_data_reg;
    utf8v_state_t state_reg;
    utf8v_state_t state_next;
    logic         result_bit;
    logic         in_is_term;
    logic         out_free;
    logic         in_fire;
    logic         out_load;

    assign in_is_term = (in_byte_reg == BYTE_TERM);
    assign out_free   = !out_valid_reg || m_tready;
    assign in_fire    = in_valid_reg && (!in_is_term || out_free);
    assign out_load   = in_fire && in_is_term;
    assign s_tready   = !in_valid_reg || in_fire;

    utf8v_step u_step (
        .data_byte    (in_byte_reg),
        .state_cur    (state_reg),
        .state_nxt    (state_next),
        .string_valid (result_bit)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_CLEAR;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (in_fire) begin
                state_reg <= state_next;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
        if (out_load) begin
            out_data_reg <= result_bit;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_data_reg};

endmodule

@@ sim/utf8_stream_validator_unit_test.sv @@
module utf8_stream_validator_unit_test;
    import utf8v_pkg::*;

    localparam int N_ITEMS     = 1650;
    localparam int STALL_LIMIT = 5000;
    localparam int LONG_HOLD   = 300;
    localparam int HOLD_AT     = 600;

    typedef struct packed {
        logic [7:0] data;
        logic       typed;
        logic       verdict;
    } dir_row_t;

    // hand-checked strings: verdict typed in on each terminator
    localparam dir_row_t DIR_TAB [24] = '{
        '{BYTE_TERM, 1'b1, 1'b1},                                // empty string
        '{BYTE_TAB,  1'b0, 1'b0}, '{BYTE_LF,   1'b0, 1'b0},
        '{BYTE_CR,   1'b0, 1'b0}, '{PRINT_LO,  1'b0, 1'b0},
        '{PRINT_HI,  1'b0, 1'b0}, '{BYTE_TERM, 1'b1, 1'b1},
        '{8'h7F,     1'b0, 1'b0}, '{8'h41,     1'b0, 1'b0},      // error, then ignored byte
        '{BYTE_TERM, 1'b1, 1'b0},
        '{LEAD2_LO,  1'b0, 1'b0}, '{CONT_LO,   1'b0, 1'b0},
        '{LEAD4_F4,  1'b0, 1'b0}, '{SEC_F4_HI, 1'b0, 1'b0},
        '{CONT_HI,   1'b0, 1'b0}, '{CONT_HI,   1'b0, 1'b0},
        '{BYTE_TERM, 1'b1, 1'b1},
        '{LEAD3_ED,  1'b0, 1'b0}, '{SEC_E0_LO, 1'b0, 1'b0},      // surrogate
        '{BYTE_TERM, 1'b1, 1'b0},
        '{LEAD2_HI,  1'b0, 1'b0}, '{BYTE_TERM, 1'b1, 1'b0},      // ends inside a sequence
        '{8'hFF,     1'b0, 1'b0}, '{BYTE_TERM, 1'b1, 1'b0}
    };

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = BYTE_TERM;
    logic       m_tready = 1'b0;
    logic       s_tready;
    logic       m_tvalid;
    logic [7:0] m_tdata;

    utf8v_state_t scan_state = STATE_CLEAR;
    bit           verdict_q[$];
    logic [7:0]   str_bytes[$];
    int           err_cnt      = 0;
    int           sent         = 0;
    int           quiet        = 0;
    bit           src_steady   = 1'b0;
    logic         hold_request = 1'b0;
    bit           want_valid;

    utf8_stream_validator_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic bit in_span(logic [7:0] b, logic [7:0] lo, logic [7:0] hi);
        return b >= lo && b <= hi;
    endfunction

    function automatic bit second_fits(logic [7:0] b, second_class_t cls);
        case (cls)
            CLS_E0:  return in_span(b, SEC_E0_LO, CONT_HI);
            CLS_ED:  return in_span(b, CONT_LO, SEC_ED_HI);
            CLS_F0:  return in_span(b, SEC_F0_LO, CONT_HI);
            CLS_F4:  return in_span(b, CONT_LO, SEC_F4_HI);
            default: return in_span(b, CONT_LO, CONT_HI);
        endcase
    endfunction

    function automatic void open_seq(logic [1:0] left, second_class_t cls);
        scan_state.cont_left    = left;
        scan_state.second_class = cls;
        scan_state.at_second    = 1'b1;
    endfunction

    function automatic void scan_lead(logic [7:0] b);
        if (b == BYTE_TAB || b == BYTE_LF || b == BYTE_CR || in_span(b, PRINT_LO, PRINT_HI)) begin
        end else if (in_span(b, LEAD2_LO, LEAD2_HI)) begin
            open_seq(2'd1, CLS_NORMAL);
        end else if (b == LEAD3_E0) begin
            open_seq(2'd2, CLS_E0);
        end else if (b == LEAD3_ED) begin
            open_seq(2'd2, CLS_ED);
        end else if (b > LEAD3_E0 && b <= LEAD3_HI) begin
            open_seq(2'd2, CLS_NORMAL);
        end else if (b == LEAD4_F0) begin
            open_seq(2'd3, CLS_F0);
        end else if (b == LEAD4_F4) begin
            open_seq(2'd3, CLS_F4);
        end else if (b > LEAD4_F0 && b < LEAD4_F4) begin
            open_seq(2'd3, CLS_NORMAL);
        end else begin
            scan_state.error_seen = 1'b1;
        end
    endfunction

    // advances the string scan by one byte; a verdict comes only on the terminator
    function automatic void scan_byte(input logic [7:0] b, output bit has_verdict,
                                      output bit verdict);
        bit good;
        has_verdict = 1'b0;
        verdict     = 1'b0;
        if (b == BYTE_TERM) begin
            has_verdict = 1'b1;
            verdict     = !scan_state.error_seen && scan_state.cont_left == 2'd0;
            scan_state  = STATE_CLEAR;
        end else if (scan_state.error_seen) begin
        end else if (scan_state.cont_left != 2'd0) begin
            good = scan_state.at_second ? second_fits(b, scan_state.second_class)
                                        : in_span(b, CONT_LO, CONT_HI);
            scan_state.at_second    = 1'b0;
            scan_state.second_class = CLS_NORMAL;
            if (!good) begin
                scan_state.error_seen = 1'b1;
                scan_state.cont_left  = 2'd0;
            end else begin
                scan_state.cont_left = scan_state.cont_left - 2'd1;
            end
        end else begin
            scan_lead(b);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99, 0);
        if (src_steady || r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(3, 1);
        else
            return $urandom_range(30, 5);
    endfunction

    task automatic send_byte(input logic [7:0] b, input bit typed, input bit typed_verdict);
        bit has_verdict;
        bit verdict;
        int gap;
        s_tdata  <= b;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        scan_byte(b, has_verdict, verdict);
        if (has_verdict)
            verdict_q.push_back(typed ? typed_verdict : verdict);
        sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic logic [7:0] rand_cont();
        return 8'($urandom_range(CONT_HI, CONT_LO));
    endfunction

    // one well-formed character of the restricted set
    function automatic void push_char();
        int r;
        logic [7:0] lead;
        r = $urandom_range(9, 0);
        if (r < 4) begin
            if ($urandom_range(9, 0) == 0) begin
                case ($urandom_range(2, 0))
                    0:       str_bytes.push_back(BYTE_TAB);
                    1:       str_bytes.push_back(BYTE_LF);
                    default: str_bytes.push_back(BYTE_CR);
                endcase
            end else begin
                str_bytes.push_back(8'($urandom_range(PRINT_HI, PRINT_LO)));
            end
        end else if (r < 6) begin
            str_bytes.push_back(8'($urandom_range(LEAD2_HI, LEAD2_LO)));
            str_bytes.push_back(rand_cont());
        end else if (r < 8) begin
            case ($urandom_range(3, 0))
                0: begin
                    str_bytes.push_back(LEAD3_E0);
                    str_bytes.push_back(8'($urandom_range(CONT_HI, SEC_E0_LO)));
                end
                1: begin
                    str_bytes.push_back(LEAD3_ED);
                    str_bytes.push_back(8'($urandom_range(SEC_ED_HI, CONT_LO)));
                end
                default: begin
                    lead = 8'($urandom_range(LEAD3_HI, 8'hE1));
                    str_bytes.push_back(lead);
                    if (lead == LEAD3_ED)
                        str_bytes.push_back(8'($urandom_range(SEC_ED_HI, CONT_LO)));
                    else
                        str_bytes.push_back(rand_cont());
                end
            endcase
            str_bytes.push_back(rand_cont());
        end else begin
            case ($urandom_range(2, 0))
                0: begin
                    str_bytes.push_back(LEAD4_F0);
                    str_bytes.push_back(8'($urandom_range(CONT_HI, SEC_F0_LO)));
                end
                1: begin
                    str_bytes.push_back(LEAD4_F4);
                    str_bytes.push_back(8'($urandom_range(SEC_F4_HI, CONT_LO)));
                end
                default: begin
                    str_bytes.push_back(8'($urandom_range(8'hF3, 8'hF1)));
                    str_bytes.push_back(rand_cont());
                end
            endcase
            str_bytes.push_back(rand_cont());
            str_bytes.push_back(rand_cont());
        end
    endfunction

    // damage a well-formed string: bad byte, cut tail, stray byte or pure noise
    function automatic void mangle_string();
        int n;
        case ($urandom_range(3, 0))
            0: if (str_bytes.size() > 0)
                   str_bytes[$urandom_range(str_bytes.size() - 1, 0)] = 8'($urandom_range(255, 1));
            1: if (str_bytes.size() > 0)
                   void'(str_bytes.pop_back());
            2: str_bytes.insert($urandom_range(str_bytes.size(), 0), 8'($urandom_range(255, 0)));
            default: begin
                str_bytes.delete();
                n = $urandom_range(6, 1);
                repeat (n) str_bytes.push_back(8'($urandom_range(255, 0)));
            end
        endcase
    endfunction

    initial begin : stimulus
        int  n_chars;
        bit  hold_sent;
        hold_sent = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < $size(DIR_TAB); i++)
            send_byte(DIR_TAB[i].data, DIR_TAB[i].typed, DIR_TAB[i].verdict);
        s_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);

        while (sent < N_ITEMS) begin
            if (!hold_sent && sent >= HOLD_AT) begin
                hold_request <= 1'b1;
                hold_sent = 1'b1;
            end
            src_steady = ($urandom_range(5, 0) == 0);
            str_bytes.delete();
            n_chars = ($urandom_range(9, 0) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 0);
            repeat (n_chars) push_char();
            if ($urandom_range(3, 0) == 0)
                mangle_string();
            foreach (str_bytes[i])
                send_byte(str_bytes[i], 1'b0, 1'b0);
            send_byte(BYTE_TERM, 1'b0, 1'b0);
        end
        s_tvalid <= 1'b0;

        while (verdict_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (err_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // receiver: random ready with short and long holds, one very long hold on request
    initial begin : result_sink
        int  hold;
        int  r;
        int  mode_cnt;
        bit  steady;
        bit  hold_done;
        hold      = 0;
        mode_cnt  = 0;
        steady    = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(posedge aclk);
            mode_cnt++;
            if (mode_cnt == 64) begin
                mode_cnt = 0;
                steady   = ($urandom_range(3, 0) == 0);
            end
            r = $urandom_range(99, 0);
            if (hold_request && !hold_done) begin
                hold_done = 1'b1;
                hold      = LONG_HOLD;
                m_tready <= 1'b0;
            end else if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (steady || r < 70) begin
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b0;
                hold = (r < 97) ? $urandom_range(3, 0) : $urandom_range(40, 5);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (verdict_q.size() == 0) begin
                $error("string_valid: result transaction with no string pending, got %0d",
                       m_tdata[0]);
                err_cnt++;
            end else begin
                want_valid = verdict_q.pop_front();
                if (m_tdata[0] !== want_valid) begin
                    $error("string_valid: expected %0d, got %0d", want_valid, m_tdata[0]);
                    err_cnt++;
                end
                if (m_tdata[7:1] !== 7'd0) begin
                    $error("m_tdata[7:1]: expected 0, got %0h", m_tdata[7:1]);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog: cycles in which no transaction moves on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule

@@ sim.f @@
sv/utf8v_pkg.sv
sv/utf8v_step.sv
sv/utf8_stream_validator_unit.sv
sim/utf8_stream_validator_unit_test.sv
